// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/imcc_pkg.sv =====
`timescale 1ns / 1ps

package imcc_pkg;

    localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;
    localparam logic [63:0] GOLDEN      = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] FOLD_MUL    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FOLD_SEED   = 64'h243f6a8885a308d3;
    localparam logic [63:0] SEED_RESET  = 64'h517cc1b727220a95;
    localparam logic [63:0] ROUNDS_RESET = 64'd100000;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 64;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INIT_SEED   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROUND_COUNT = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_A,
        ST_XS_B,
        ST_MUL_B,
        ST_ADD_R,
        ST_FOLD_LD,
        ST_MUL_F,
        ST_FOLD_ADD
    } state_t;

    // Partial products of a 64 x 64 multiply, low 64 bits kept
    typedef enum logic [1:0] {
        PH_LO_LO,
        PH_HI_LO,
        PH_LO_HI
    } mul_phase_t;

endpackage

// ===== rtl/iterated_mix_chunk_checksum.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Mixes one chunk per transaction and folds it into a running checksum. The
// seed (chunk_index + 1) ^ seed register goes through round_count SplitMix64-style
// rounds; the final state comes out as chunk_value together with the updated
// running_checksum, one result per input, in arrival order. A single 32 x 32
// multiplier does every 64-bit multiply as three partial products; each round
// runs MUL_A, XS_B, MUL_B and ADD_R, then the fold runs FOLD_LD, MUL_F and
// FOLD_ADD, which waits on a stalled output; in_stall stays high from the
// accepting edge until the result is written. The result sits in an output
// register, so a waiting result does not hold off the next input, but a new
// result is not finished while the previous one is still stalled.
// The seed and round count registers must be written only while the block is
// idle.
module iterated_mix_chunk_checksum #(
    parameter int INDEX_BITS = 32,
    parameter int ROUND_BITS = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_we,
    input  logic [imcc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [imcc_pkg::CFG_DATA_BITS-1:0]  cfg_data,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [INDEX_BITS-1:0]              chunk_index,
    input  logic                               restart,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [63:0]                        chunk_value,
    output logic [63:0]                        running_checksum
);

    import imcc_pkg::*;

    state_t                state_reg, state_next;
    mul_phase_t            mul_ph_reg, mul_ph_next;

    logic [63:0]           init_seed_reg;
    logic [ROUND_BITS-1:0] round_count_reg;

    logic [63:0]           mix_reg, mix_next;
    logic [63:0]           fold_reg, fold_next;
    logic [ROUND_BITS-1:0] round_reg, round_next;
    logic                  restart_reg, restart_next;

    logic [63:0]           op_reg, op_next;
    logic [63:0]           acc_reg, acc_next;

    logic                  out_valid_reg, out_valid_next;
    logic [63:0]           chunk_value_reg, chunk_value_next;
    logic [63:0]           checksum_reg, checksum_next;

    logic [63:0]           mul_const;
    logic [31:0]           mul_lhs, mul_rhs;
    logic [63:0]           mul_prod;
    logic                  mul_active;

    logic [63:0]           seed;
    logic [63:0]           round_sum;
    logic [63:0]           fold_in;
    logic [63:0]           fold_sum;
    logic [ROUND_BITS-1:0] round_inc;
    logic                  in_accept;
    logic                  out_free;

    assign in_stall         = (state_reg != ST_IDLE);
    assign out_valid        = out_valid_reg;
    assign chunk_value      = chunk_value_reg;
    assign running_checksum = checksum_reg;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Shared multiplier: operand halves and constant halves by phase
    always_comb
    begin
        case (state_reg)
            ST_MUL_A: mul_const = MIX_MUL_A;
            ST_MUL_B: mul_const = MIX_MUL_B;
            default:  mul_const = FOLD_MUL;
        endcase
    end

    assign mul_lhs    = (mul_ph_reg == PH_HI_LO) ? op_reg[63:32] : op_reg[31:0];
    assign mul_rhs    = (mul_ph_reg == PH_LO_HI) ? mul_const[63:32] : mul_const[31:0];
    assign mul_prod   = {32'b0, mul_lhs} * {32'b0, mul_rhs};
    assign mul_active = (state_reg == ST_MUL_A) || (state_reg == ST_MUL_B)
                        || (state_reg == ST_MUL_F);

    assign seed      = (64'(chunk_index) + 64'd1) ^ init_seed_reg;
    assign round_sum = (acc_reg ^ (acc_reg >> 31)) + (64'(round_reg) ^ GOLDEN);
    assign fold_in   = (restart_reg ? FOLD_SEED : fold_reg) ^ mix_reg;
    assign fold_sum  = acc_reg + GOLDEN;
    assign round_inc = round_reg + ROUND_BITS'(1);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_seed_reg   <= SEED_RESET;
            round_count_reg <= ROUNDS_RESET[ROUND_BITS-1:0];
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_INIT_SEED:   init_seed_reg   <= cfg_data;
                CFG_ROUND_COUNT: round_count_reg <= cfg_data[ROUND_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_ph_reg    <= PH_LO_LO;
            out_valid_reg <= 1'b0;
            fold_reg      <= FOLD_SEED;
            mix_reg       <= '0;
            round_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_ph_reg    <= mul_ph_next;
            out_valid_reg <= out_valid_next;
            fold_reg      <= fold_next;
            mix_reg       <= mix_next;
            round_reg     <= round_next;
        end
    end

    always_ff @(posedge clk)
    begin
        restart_reg     <= restart_next;
        op_reg          <= op_next;
        acc_reg         <= acc_next;
        chunk_value_reg <= chunk_value_next;
        checksum_reg    <= checksum_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        mul_ph_next      = mul_ph_reg;
        mix_next         = mix_reg;
        fold_next        = fold_reg;
        round_next       = round_reg;
        restart_next     = restart_reg;
        op_next          = op_reg;
        acc_next         = acc_reg;
        chunk_value_next = chunk_value_reg;
        checksum_next    = checksum_reg;
        out_valid_next   = out_valid_reg && out_stall;

        // Accumulate partial products; high half only needs the low 32 bits
        if (mul_active)
        begin
            case (mul_ph_reg)
                PH_LO_LO:
                begin
                    acc_next    = mul_prod;
                    mul_ph_next = PH_HI_LO;
                end
                PH_HI_LO:
                begin
                    acc_next[63:32] = acc_reg[63:32] + mul_prod[31:0];
                    mul_ph_next     = PH_LO_HI;
                end
                default:
                begin
                    acc_next[63:32] = acc_reg[63:32] + mul_prod[31:0];
                    mul_ph_next     = PH_LO_LO;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    mix_next     = seed;
                    op_next      = seed ^ (seed >> 30);
                    round_next   = '0;
                    restart_next = restart;
                    state_next   = (round_count_reg == '0) ? ST_FOLD_LD : ST_MUL_A;
                end
            end
            ST_MUL_A:
            begin
                if (mul_ph_reg == PH_LO_HI)
                    state_next = ST_XS_B;
            end
            ST_XS_B:
            begin
                op_next    = acc_reg ^ (acc_reg >> 27);
                state_next = ST_MUL_B;
            end
            ST_MUL_B:
            begin
                if (mul_ph_reg == PH_LO_HI)
                    state_next = ST_ADD_R;
            end
            ST_ADD_R:
            begin
                mix_next   = round_sum;
                op_next    = round_sum ^ (round_sum >> 30);
                round_next = round_inc;
                state_next = (round_inc == round_count_reg) ? ST_FOLD_LD : ST_MUL_A;
            end
            ST_FOLD_LD:
            begin
                op_next    = {fold_in[32:0], fold_in[63:33]};
                state_next = ST_MUL_F;
            end
            ST_MUL_F:
            begin
                if (mul_ph_reg == PH_LO_HI)
                    state_next = ST_FOLD_ADD;
            end
            ST_FOLD_ADD:
            begin
                // Hold until the output register frees up
                if (out_free)
                begin
                    fold_next        = fold_sum;
                    chunk_value_next = mix_reg;
                    checksum_next    = fold_sum;
                    out_valid_next   = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_accept, in_stall, "accept did not raise stall")
    `ASSERT_NEXT(a_fold_waits, clk, rst_n, (state_reg == ST_FOLD_ADD) && out_valid_reg && out_stall, (state_reg == ST_FOLD_ADD) && $stable(fold_reg), "fold finished into stalled output")
    `ASSERT_IMPLY(a_phase_in_mul, clk, rst_n, mul_ph_reg != PH_LO_LO, mul_active, "multiply phase outside multiply state")
    `ASSERT_IMPLY(a_round_bound, clk, rst_n, state_reg == ST_MUL_A, round_reg < round_count_reg, "round counter past round count")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import imcc_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED_3 = 2'd3;
    localparam int PRESSURE_CYCLES = 400;

    typedef struct packed {
        logic [63:0] value;
        logic [63:0] checksum;
    } chunk_result_t;

    class chunk_scoreboard;
        bit [63:0]     init_seed;
        bit [19:0]     round_count;
        bit [63:0]     fold_acc;
        chunk_result_t results_due[$];
        int            mismatches;

        function new();
            init_seed   = SEED_RESET;
            round_count = ROUNDS_RESET[19:0];
            fold_acc    = FOLD_SEED;
            mismatches  = 0;
        endfunction

        function void set_register(logic [CFG_INDEX_BITS-1:0] idx, logic [63:0] data);
            if (idx == CFG_INIT_SEED)
                init_seed = data;
            else if (idx == CFG_ROUND_COUNT)
                round_count = data[19:0];
        endfunction

        function bit [63:0] mix_chunk(logic [31:0] idx);
            bit [63:0] s;
            s = ({32'd0, idx} + 64'd1) ^ init_seed;
            for (int unsigned r = 0; r < 32'(round_count); r++)
            begin
                s = s ^ (s >> 30);
                s = s * MIX_MUL_A;
                s = s ^ (s >> 27);
                s = s * MIX_MUL_B;
                s = s ^ (s >> 31);
                s = s + (64'(r) ^ GOLDEN);
            end
            return s;
        endfunction

        function void note_chunk(logic [31:0] idx, logic rs);
            chunk_result_t e;
            bit [63:0]     c;
            e.value = mix_chunk(idx);
            c = rs ? FOLD_SEED : fold_acc;
            c = c ^ e.value;
            c = {c[32:0], c[63:33]};
            c = c * FOLD_MUL + GOLDEN;
            fold_acc   = c;
            e.checksum = c;
            results_due.push_back(e);
        endfunction

        function void check_result(logic [63:0] value, logic [63:0] checksum);
            chunk_result_t e;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected result chunk_value=%h running_checksum=%h",
                         $time, value, checksum);
                mismatches++;
                return;
            end
            e = results_due.pop_front();
            if (value !== e.value)
            begin
                $display("%0t: chunk_value expected %h actual %h", $time, e.value, value);
                mismatches++;
            end
            if (checksum !== e.checksum)
            begin
                $display("%0t: running_checksum expected %h actual %h",
                         $time, e.checksum, checksum);
                mismatches++;
            end
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [31:0]               chunk_index = '0;
    logic                      restart = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [63:0]               chunk_value;
    logic [63:0]               running_checksum;

    chunk_scoreboard sb;
    bit src_idle_en  = 1'b0;
    bit sink_idle_en = 1'b0;
    bit hold_output  = 1'b0;

    iterated_mix_chunk_checksum u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .chunk_index      (chunk_index),
        .restart          (restart),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .chunk_value      (chunk_value),
        .running_checksum (running_checksum)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(chunk_value, running_checksum);
    end

    // Receiver side: random stall bursts, plus one long hold to back up the block
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_output)
            begin
                out_stall <= 1'b1;
                repeat (PRESSURE_CYCLES) @(posedge clk);
                hold_output = 1'b0;
            end
            else if (sink_idle_en && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
        end
    end

    task automatic send_chunk(input logic [31:0] idx, input logic rs);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 19) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        chunk_index <= idx;
        restart     <= rs;
        do @(posedge clk); while (in_stall);
        sb.note_chunk(idx, rs);
    endtask

    // Write seed, round count and one unmapped index, back to back
    task automatic program_regs(input logic [63:0] seed, input logic [63:0] rounds_word,
                                input logic [CFG_INDEX_BITS-1:0] spare);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INIT_SEED;
        cfg_data  <= seed;
        sb.set_register(CFG_INIT_SEED, seed);
        @(posedge clk);
        cfg_index <= CFG_ROUND_COUNT;
        cfg_data  <= rounds_word;
        sb.set_register(CFG_ROUND_COUNT, rounds_word);
        @(posedge clk);
        cfg_index <= spare;
        cfg_data  <= junk;
        sb.set_register(spare, junk);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every result, then let the pipeline go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: full default round count, checksum from its seed
        send_chunk(32'd5, 1'b0);
        settle();

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;

        // Zero rounds emits the seeded state; top index carries into bit 32
        program_regs(64'd0, 64'd0, CFG_UNMAPPED_2);
        send_chunk(32'd0, 1'b0);
        send_chunk(32'hffff_ffff, 1'b0);
        send_chunk(32'h8000_0000, 1'b1);
        send_chunk(32'h7fff_ffff, 1'b0);
        settle();

        // All-ones seed; bits above the round count field are dropped
        program_regs(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_fff0_0001, CFG_UNMAPPED_3);
        send_chunk(32'hffff_ffff, 1'b1);
        send_chunk(32'd0, 1'b0);
        send_chunk(32'h1234_5678, 1'b0);
        settle();

        program_regs({$urandom, $urandom}, 64'hffff_ffff_fff0_0005, CFG_UNMAPPED_2);
        send_chunk(32'h5555_5555, 1'b0);
        send_chunk(32'haaaa_aaaa, 1'b1);
        send_chunk($urandom, 1'b0);
        settle();

        for (int ph = 0; ph < 5; ph++)
        begin
            program_regs({$urandom, $urandom},
                         {$urandom, 12'($urandom), 20'($urandom_range(0, 12))},
                         ph[0] ? CFG_UNMAPPED_3 : CFG_UNMAPPED_2);
            src_idle_en  = (ph < 4);
            sink_idle_en = (ph < 4);
            if (ph == 1)
                hold_output = 1'b1;
            for (int k = 0; k < 20; k++)
                send_chunk($urandom, $urandom_range(0, 5) == 0);
            settle();
        end

        if (sb.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: reports a failure and stops if the run is still going
    initial
    begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
